>>> hw/rtl/scfb_pkg.sv
// Shared types, constants and codes for the servo command frame builder.
package scfb_pkg;

  // Longest frame in bytes and the width of a byte count or byte index
  localparam int FRAME_MAX = 10;
  localparam int CNT_W     = $clog2(FRAME_MAX + 1);

  // Default depth of the command queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // Saturation limits
  localparam logic [15:0]        ANGLE_MAX   = 16'd1000;
  localparam logic [15:0]        TIME_MAX    = 16'd30000;
  localparam logic signed [15:0] SPEED_LIMIT = 16'sd1000;

  // Length byte values and the resulting frame sizes (length plus three)
  localparam logic [7:0] LEN_LONG = 8'd7;
  localparam logic [7:0] LEN_LOAD = 8'd4;
  localparam logic [7:0] LEN_READ = 8'd3;
  localparam logic [CNT_W-1:0] NB_LONG = CNT_W'(7 + 3);
  localparam logic [CNT_W-1:0] NB_LOAD = CNT_W'(4 + 3);
  localparam logic [CNT_W-1:0] NB_READ = CNT_W'(3 + 3);

  // Command kinds
  typedef enum logic [1:0] {
    ACT_MOVE = 2'd0,
    ACT_MODE = 2'd1,
    ACT_LOAD = 2'd2,
    ACT_READ = 2'd3
  } action_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_START_BYTE  = 2'd0,
    REG_MOVE_OPCODE = 2'd1,
    REG_MODE_OPCODE = 2'd2,
    REG_LOAD_OPCODE = 2'd3
  } reg_idx_t;

  // One fully built frame, byte 0 sent first
  typedef struct packed {
    logic [FRAME_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]          nbytes;
  } frame_t;

endpackage

>>> hw/rtl/scfb_if.sv
// Channel interfaces: command input, frame byte output, configuration writes.
interface scfb_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [7:0]        servo_id;
  logic [15:0]       target_angle;
  logic [15:0]       move_time;
  logic [7:0]        motor_mode;
  logic signed [15:0] spin_speed;
  logic              load_flag;
  logic [7:0]        read_code;

  modport source (output valid, action, servo_id, target_angle, move_time,
                  motor_mode, spin_speed, load_flag, read_code, input ready);
  modport sink   (input valid, action, servo_id, target_angle, move_time,
                  motor_mode, spin_speed, load_flag, read_code, output ready);
endinterface

interface scfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface scfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/scfb_front.sv
// Front end: config registers, command accept, clamping and frame assembly.
module scfb_front (
  input  logic            clk,
  input  logic            rst_n,
  scfb_in_if.sink         in_ch,
  scfb_cfg_if.sink        cfg_ch,
  input  logic            q_full,
  output logic            q_push,
  output scfb_pkg::frame_t q_frame
);
  import scfb_pkg::*;

  logic [7:0] start_byte_r, move_opcode_r, mode_opcode_r, load_opcode_r;
  logic [6:0][7:0] body;      // id through last parameter
  logic [7:0] csum_acc;
  logic [7:0] csum;
  logic [15:0] angle_c, time_c;
  logic signed [15:0] speed_c;
  action_t act;

  // Config registers, always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r  <= 8'd85;
      move_opcode_r <= 8'd1;
      mode_opcode_r <= 8'd29;
      load_opcode_r <= 8'd31;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_START_BYTE:  start_byte_r  <= cfg_ch.data;
        REG_MOVE_OPCODE: move_opcode_r <= cfg_ch.data;
        REG_MODE_OPCODE: mode_opcode_r <= cfg_ch.data;
        REG_LOAD_OPCODE: load_opcode_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Accept whenever the queue has room
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign act         = action_t'(in_ch.action);

  // Saturation
  always_comb begin
    angle_c = (in_ch.target_angle > ANGLE_MAX) ? ANGLE_MAX : in_ch.target_angle;
    time_c  = (in_ch.move_time > TIME_MAX) ? TIME_MAX : in_ch.move_time;
    if (in_ch.spin_speed > SPEED_LIMIT) begin
      speed_c = SPEED_LIMIT;
    end else if (in_ch.spin_speed < -SPEED_LIMIT) begin
      speed_c = -SPEED_LIMIT;
    end else begin
      speed_c = in_ch.spin_speed;
    end
  end

  // Frame body per command; unused slots are zero so they drop out of the sum
  always_comb begin
    body    = '0;
    body[0] = in_ch.servo_id;
    case (act)
      ACT_MOVE: begin
        body[1] = LEN_LONG;
        body[2] = move_opcode_r;
        body[3] = angle_c[7:0];
        body[4] = angle_c[15:8];
        body[5] = time_c[7:0];
        body[6] = time_c[15:8];
      end
      ACT_MODE: begin
        body[1] = LEN_LONG;
        body[2] = mode_opcode_r;
        body[3] = in_ch.motor_mode;
        body[4] = 8'd0;
        body[5] = speed_c[7:0];
        body[6] = speed_c[15:8];
      end
      ACT_LOAD: begin
        body[1] = LEN_LOAD;
        body[2] = load_opcode_r;
        body[3] = {7'd0, in_ch.load_flag};
      end
      default: begin
        body[1] = LEN_READ;
        body[2] = in_ch.read_code;
      end
    endcase
  end

  // Inverted low byte of the body sum
  always_comb begin
    csum_acc = '0;
    for (int i = 0; i < 7; i++) begin
      csum_acc = csum_acc + body[i];
    end
    csum = ~csum_acc;
  end

  // Place start bytes, body and checksum
  always_comb begin
    q_frame          = '0;
    q_frame.bytes[0] = start_byte_r;
    q_frame.bytes[1] = start_byte_r;
    for (int i = 0; i < 7; i++) begin
      q_frame.bytes[i+2] = body[i];
    end
    case (act)
      ACT_MOVE, ACT_MODE: begin
        q_frame.bytes[9] = csum;
        q_frame.nbytes   = NB_LONG;
      end
      ACT_LOAD: begin
        q_frame.bytes[6] = csum;
        q_frame.nbytes   = NB_LOAD;
      end
      default: begin
        q_frame.bytes[5] = csum;
        q_frame.nbytes   = NB_READ;
      end
    endcase
  end

endmodule

>>> hw/rtl/scfb_queue.sv
// Short frame queue between the front and back ends.
module scfb_queue #(
  parameter int DEPTH = scfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  scfb_pkg::frame_t wr_frame,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output scfb_pkg::frame_t rd_frame
);
  import scfb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  frame_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_frame  = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_frame;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

>>> hw/rtl/scfb_back.sv
// Back end: sends the queued frame one word per handshake, flags the last word.
module scfb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  scfb_pkg::frame_t q_frame,
  output logic             q_pop,
  scfb_out_if.source       out_ch
);
  import scfb_pkg::*;

  frame_t           cur_r;
  logic [CNT_W-1:0] idx_r;
  logic             busy_r;
  logic             take;
  logic             last;

  assign take = busy_r && out_ch.ready;
  assign last = (idx_r == cur_r.nbytes - 1'b1);

  // Load the next frame while the current last word leaves
  assign q_pop = q_not_empty && (!busy_r || (take && last));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (take) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Output word
  assign out_ch.valid      = busy_r;
  assign out_ch.frame_byte = cur_r.bytes[idx_r];
  assign out_ch.last_byte  = last;

  a_frame_size: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cur_r.nbytes == NB_LONG || cur_r.nbytes == NB_LOAD ||
                cur_r.nbytes == NB_READ))
    else $error("active frame has a bad size");
  a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < cur_r.nbytes))
    else $error("word index beyond frame end");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_ch.ready) |=> (busy_r && $stable(idx_r)))
    else $error("frame advanced while stalled");

endmodule

>>> hw/rtl/servo_command_frame_builder.sv
// Top level of the servo command frame builder: front, queue and back end.
//
//   port     dir   words                      handshake
//   in_ch    in    one servo command          valid/ready
//   out_ch   out   one frame byte, last flag  valid/ready
//   cfg_ch   in    register index and data    valid/ready, always ready
//
// A command becomes a frame of 6, 7 or 10 bytes on the byte output;
// the single byte-wide output port sets the command rate.
// The front builds a whole frame, checksum included, in the accept cycle.
// The queue holds QUEUE_DEPTH frames, so commands are taken while the back
// end is still sending; in_ch stalls only when the queue is full.
// Synchronous active-low reset restores the default registers, empties queue.
module servo_command_frame_builder #(
  parameter int QUEUE_DEPTH = scfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  scfb_in_if.sink   in_ch,
  scfb_out_if.source out_ch,
  scfb_cfg_if.sink  cfg_ch
);
  import scfb_pkg::*;

  frame_t push_frame, pop_frame;
  logic   push, pop, q_full, q_not_empty;

  scfb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg_ch  (cfg_ch),
    .q_full  (q_full),
    .q_push  (push),
    .q_frame (push_frame)
  );

  scfb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_frame  (push_frame),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .rd_frame  (pop_frame)
  );

  scfb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_frame     (pop_frame),
    .q_pop       (pop),
    .out_ch      (out_ch)
  );

endmodule

>>> dv/scfb_checker.sv
// Frame checker: watches the command, frame byte and register channels, predicts and compares.
module scfb_checker (
  input  logic        clk,
  input  logic        rst_n,
  scfb_in_if          in_mon,
  scfb_out_if         out_mon,
  scfb_cfg_if         cfg_mon,
  output int unsigned fails,
  output int unsigned pending,
  output int unsigned bytes_checked
);
  import scfb_pkg::*;

  // Saturation limits and length bytes of the servo protocol
  localparam logic [15:0]        ANGLE_CAP   = 16'd1000;
  localparam logic [15:0]        TIME_CAP    = 16'd30000;
  localparam logic signed [15:0] SPEED_CEIL  = 16'sd1000;
  localparam logic signed [15:0] SPEED_FLOOR = -16'sd1000;
  localparam logic [7:0]         LONG_LEN    = 8'd7;
  localparam logic [7:0]         TORQUE_LEN  = 8'd4;
  localparam logic [7:0]         QUERY_LEN   = 8'd3;

  // Power-on register values
  localparam logic [7:0] START_DEF   = 8'd85;
  localparam logic [7:0] MOVE_OP_DEF = 8'd1;
  localparam logic [7:0] MODE_OP_DEF = 8'd29;
  localparam logic [7:0] LOAD_OP_DEF = 8'd31;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_word_t;

  frame_word_t frame_q[$];
  logic [7:0]  start_reg, move_op, mode_op, load_op;
  int unsigned fail_cnt    = 0;
  int unsigned word_cnt    = 0;
  int unsigned queued_cnt  = 0;

  assign fails         = fail_cnt;
  assign bytes_checked = word_cnt;
  assign pending       = queued_cnt;

  task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
    $display("ERROR: word %0d %s: expected %02h, got %02h", word_cnt, what, want, got);
    fail_cnt++;
  endtask

  // Build the whole frame of the accepted command and queue its bytes
  task automatic predict_frame();
    logic [7:0]         b [0:9];
    int                 n;
    logic [7:0]         sum;
    logic [15:0]        ang;
    logic [15:0]        tim;
    logic signed [15:0] spd;
    for (int i = 0; i < 10; i++) b[i] = 8'h00;
    b[0] = start_reg;
    b[1] = start_reg;
    b[2] = in_mon.servo_id;
    case (action_t'(in_mon.action))
      ACT_MOVE: begin
        ang  = (in_mon.target_angle > ANGLE_CAP) ? ANGLE_CAP : in_mon.target_angle;
        tim  = (in_mon.move_time > TIME_CAP) ? TIME_CAP : in_mon.move_time;
        b[3] = LONG_LEN;
        b[4] = move_op;
        b[5] = ang[7:0];
        b[6] = ang[15:8];
        b[7] = tim[7:0];
        b[8] = tim[15:8];
        n    = 10;
      end
      ACT_MODE: begin
        spd = in_mon.spin_speed;
        if (spd > SPEED_CEIL) spd = SPEED_CEIL;
        else if (spd < SPEED_FLOOR) spd = SPEED_FLOOR;
        b[3] = LONG_LEN;
        b[4] = mode_op;
        b[5] = in_mon.motor_mode;
        b[6] = 8'h00;
        b[7] = spd[7:0];
        b[8] = spd[15:8];
        n    = 10;
      end
      ACT_LOAD: begin
        b[3] = TORQUE_LEN;
        b[4] = load_op;
        b[5] = {7'd0, in_mon.load_flag};
        n    = 7;
      end
      default: begin
        b[3] = QUERY_LEN;
        b[4] = in_mon.read_code;
        n    = 6;
      end
    endcase
    // inverted sum of id through last parameter
    sum = 8'h00;
    for (int i = 2; i < n - 1; i++) sum += b[i];
    b[n-1] = ~sum;
    for (int i = 0; i < n; i++) frame_q.push_back('{value: b[i], last: (i == n - 1)});
  endtask

  task automatic check_word();
    frame_word_t want;
    if (frame_q.size() == 0) begin
      report("byte with no frame pending", 8'h00, out_mon.frame_byte);
    end else begin
      want = frame_q.pop_front();
      if (out_mon.frame_byte !== want.value)
        report("frame_byte", want.value, out_mon.frame_byte);
      if (out_mon.last_byte !== want.last)
        report("last_byte", {7'd0, want.last}, {7'd0, out_mon.last_byte});
    end
    word_cnt++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start_reg = START_DEF;
      move_op   = MOVE_OP_DEF;
      mode_op   = MODE_OP_DEF;
      load_op   = LOAD_OP_DEF;
      frame_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_word();
      if (in_mon.valid && in_mon.ready) predict_frame();
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (reg_idx_t'(cfg_mon.index))
          REG_START_BYTE:  start_reg = cfg_mon.data;
          REG_MOVE_OPCODE: move_op   = cfg_mon.data;
          REG_MODE_OPCODE: mode_op   = cfg_mon.data;
          REG_LOAD_OPCODE: load_op   = cfg_mon.data;
          default: ;
        endcase
      end
    end
    queued_cnt <= frame_q.size();
  end

endmodule

>>> dv/tb.sv
// Testbench top: clock, reset, command and register stimulus, output stalls and verdict.
module tb;
  import scfb_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned PHASE_ITEMS = 74;
  localparam int unsigned PHASES      = 5;

  // Power-on register values, restored in the last phase
  localparam logic [7:0] START_DEF   = 8'd85;
  localparam logic [7:0] MOVE_OP_DEF = 8'd1;
  localparam logic [7:0] MODE_OP_DEF = 8'd29;
  localparam logic [7:0] LOAD_OP_DEF = 8'd31;

  typedef struct {
    action_t            act;
    logic [7:0]         id;
    logic [15:0]        angle;
    logic [15:0]        mtime;
    logic [7:0]         mode;
    logic signed [15:0] speed;
    logic               flag;
    logic [7:0]         code;
  } servo_cmd_t;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  bit          steady = 1'b0;
  int unsigned fails, pending, bytes_checked;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  int unsigned settings_used = 1;
  int unsigned sent_by_act [4] = '{0, 0, 0, 0};

  scfb_in_if  in_ch ();
  scfb_out_if out_ch ();
  scfb_cfg_if cfg_ch ();

  servo_command_frame_builder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  scfb_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .fails         (fails),
    .pending       (pending),
    .bytes_checked (bytes_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned sender_gap();
    if (steady || $urandom_range(0, 99) < 55) return 0;
    return idle_len();
  endfunction

  // Receiver stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 20) begin
      stall_left = idle_len() - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles where no word moves on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TIMEOUT: no word accepted for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic servo_cmd_t mk(input action_t act, input logic [7:0] id,
                                    input logic [15:0] angle, input logic [15:0] mtime,
                                    input logic [7:0] mode, input logic signed [15:0] speed,
                                    input logic flag, input logic [7:0] code);
    servo_cmd_t c;
    c.act = act; c.id = id; c.angle = angle; c.mtime = mtime;
    c.mode = mode; c.speed = speed; c.flag = flag; c.code = code;
    return c;
  endfunction

  // In-range values, values near the clamp limits, full-range noise and the extremes
  function automatic logic [15:0] pick_unsigned(input logic [15:0] cap);
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, cap));
      1:       return 16'($urandom_range(cap - 8, cap + 8));
      2:       return 16'($urandom);
      default: return ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_speed();
    case ($urandom_range(0, 3))
      0:       return 16'(int'($urandom_range(0, 2000)) - 1000);
      1:       return 16'(($urandom_range(0, 1) ? 1000 : -1000) +
                          int'($urandom_range(0, 8)) - 4);
      2:       return 16'($urandom);
      default: return ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  function automatic servo_cmd_t random_cmd();
    servo_cmd_t c;
    c.act   = action_t'($urandom_range(0, 3));
    c.id    = 8'($urandom);
    c.angle = pick_unsigned(16'd1000);
    c.mtime = pick_unsigned(16'd30000);
    c.mode  = 8'($urandom);
    c.speed = pick_speed();
    c.flag  = 1'($urandom);
    c.code  = 8'($urandom);
    return c;
  endfunction

  // Present one command and hold it until accepted; returns at a falling edge
  task automatic send_cmd(input servo_cmd_t c);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.action       <= c.act;
    in_ch.servo_id     <= c.id;
    in_ch.target_angle <= c.angle;
    in_ch.move_time    <= c.mtime;
    in_ch.motor_mode   <= c.mode;
    in_ch.spin_speed   <= c.speed;
    in_ch.load_flag    <= c.flag;
    in_ch.read_code    <= c.code;
    in_ch.valid        <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent_by_act[c.act]++;
  endtask

  // Hold off the sender until every queued frame byte has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [7:0] sb, input logic [7:0] mv,
                          input logic [7:0] md, input logic [7:0] ld);
    write_reg(REG_START_BYTE, sb);
    write_reg(REG_MOVE_OPCODE, mv);
    write_reg(REG_MODE_OPCODE, md);
    write_reg(REG_LOAD_OPCODE, ld);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    servo_cmd_t directed [$];
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_MOVE;
    in_ch.servo_id     = 8'h00;
    in_ch.target_angle = 16'h0000;
    in_ch.move_time    = 16'h0000;
    in_ch.motor_mode   = 8'h00;
    in_ch.spin_speed   = 16'sh0000;
    in_ch.load_flag    = 1'b0;
    in_ch.read_code    = 8'h00;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_START_BYTE;
    cfg_ch.data        = 8'h00;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Field extremes, clamp edges and every command kind at power-on registers
    directed.push_back(mk(ACT_MOVE, 8'h00, 16'd0, 16'd0, 8'h00, 16'sd0, 1'b0, 8'h00));
    directed.push_back(mk(ACT_MOVE, 8'hFF, 16'd1000, 16'd30000, 8'h00, 16'sd0, 1'b0, 8'h00));
    directed.push_back(mk(ACT_MOVE, 8'h12, 16'd1001, 16'd30001, 8'h00, 16'sd0, 1'b0, 8'h00));
    directed.push_back(mk(ACT_MOVE, 8'hFE, 16'hFFFF, 16'hFFFF, 8'h00, 16'sd0, 1'b0, 8'h00));
    directed.push_back(mk(ACT_MOVE, 8'h01, 16'd999, 16'd29999, 8'hFF, 16'sh8000, 1'b1,
                          8'hFF));
    directed.push_back(mk(ACT_MODE, 8'h00, 16'd0, 16'd0, 8'h00, 16'sd0, 1'b0, 8'h00));
    directed.push_back(mk(ACT_MODE, 8'h22, 16'd0, 16'd0, 8'h01, 16'sd1000, 1'b0, 8'h00));
    directed.push_back(mk(ACT_MODE, 8'h33, 16'd0, 16'd0, 8'h00, 16'sd1001, 1'b0, 8'h00));
    directed.push_back(mk(ACT_MODE, 8'h44, 16'd0, 16'd0, 8'h01, 16'sh7FFF, 1'b0, 8'h00));
    directed.push_back(mk(ACT_MODE, 8'h55, 16'd0, 16'd0, 8'h00, -16'sd1000, 1'b0, 8'h00));
    directed.push_back(mk(ACT_MODE, 8'h66, 16'd0, 16'd0, 8'h01, -16'sd1001, 1'b0, 8'h00));
    directed.push_back(mk(ACT_MODE, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'sh8000, 1'b1,
                          8'hFF));
    directed.push_back(mk(ACT_MODE, 8'h77, 16'd0, 16'd0, 8'h80, -16'sd1, 1'b0, 8'h00));
    directed.push_back(mk(ACT_LOAD, 8'h00, 16'd0, 16'd0, 8'h00, 16'sd0, 1'b0, 8'h00));
    directed.push_back(mk(ACT_LOAD, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'sh7FFF, 1'b1,
                          8'hFF));
    directed.push_back(mk(ACT_READ, 8'h00, 16'd0, 16'd0, 8'h00, 16'sd0, 1'b0, 8'h00));
    directed.push_back(mk(ACT_READ, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'sh8000, 1'b1,
                          8'hFF));
    directed.push_back(mk(ACT_READ, 8'h5A, 16'd0, 16'd0, 8'h00, 16'sd0, 1'b0, 8'h1C));
    foreach (directed[i]) send_cmd(directed[i]);
    drain();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       set_regs(8'h00, 8'h00, 8'h00, 8'h00);
        1:       set_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        4:       set_regs(START_DEF, MOVE_OP_DEF, MODE_OP_DEF, LOAD_OP_DEF);
        default: set_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      steady = (ph == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) drain();
        send_cmd(random_cmd());
      end
      drain();
    end
    steady = 1'b0;

    repeat (20) @(posedge clk);
    $display("Covered %0d commands (move %0d, mode %0d, load %0d, read %0d) over %0d settings",
             sent_by_act[ACT_MOVE] + sent_by_act[ACT_MODE] + sent_by_act[ACT_LOAD] +
             sent_by_act[ACT_READ], sent_by_act[ACT_MOVE], sent_by_act[ACT_MODE],
             sent_by_act[ACT_LOAD], sent_by_act[ACT_READ], settings_used);
    $display("Compared %0d frame bytes, %0d errors, %0d bytes outstanding",
             bytes_checked, fails, pending);
    if (fails == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/scfb_pkg.sv
hw/rtl/scfb_if.sv
hw/rtl/scfb_front.sv
hw/rtl/scfb_queue.sv
hw/rtl/scfb_back.sv
hw/rtl/servo_command_frame_builder.sv
dv/scfb_checker.sv
dv/tb.sv
